### rtl/mssd_pkg.sv
package mssd_pkg;

  // Number of display positions held in the digit store.
  localparam int NUM_DIGITS = 4;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digit_vec_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SHOW = 1'b1
  } cmd_t;

  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [7:0] SEG_MINUS = 8'h40;

  // Reciprocals for exact division of a 16-bit magnitude (at most 32768) by powers of ten.
  localparam logic [15:0] RECIP_10    = 16'd52429;  // shift 19
  localparam logic [12:0] RECIP_100   = 13'd5243;   // shift 19
  localparam logic [16:0] RECIP_1000  = 17'd67109;  // shift 26
  localparam logic [13:0] RECIP_10000 = 14'd13422;  // shift 27

  localparam logic [1:0] POINT_RESET = 2'd2;

  // Segment pattern of one decimal digit, bit 0 is segment a.
  function automatic logic [7:0] seg_of_digit(digit_t d);
    logic [7:0] seg;
    unique case (d)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

### rtl/multiplexed_seven_segment_driver_unit.sv
// Four-digit multiplexed seven-segment driver. Each input word is either a
// load (command 0), which converts the signed value to the four lowest
// decimal digits of its magnitude and stores them together with the
// negative flag, or a show (command 1), which returns one result word: the
// segment pattern of the named position (a minus sign at position 0 when
// the stored flag is set, plus the decimal point at the configured
// position) and an active-low enable that selects only that position.
// Loads return nothing. The block sustains one word per clock while no
// show waits on a held result. A word is captured in the input register
// when accepted; a show passes a segment lookup on the digit store into
// the result register, a load the reciprocal multipliers into the digit
// store. A show right after a load sees the new digits. The decimal point
// position resets to 2; the user must write it through cfg_wr_en /
// cfg_wr_data only while the block is idle, which is not enforced. The
// digit store resets to zeros, so a show before any load displays zeros.
module multiplexed_seven_segment_driver_unit (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [15:0] in_value,
  input  logic       in_negative,
  input  logic [1:0] in_digit_index,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_segments,
  output logic [3:0] out_digit_enable,

  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);
  import mssd_pkg::*;

  // Input register: holds the word being worked on.
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_command_r;
  logic [15:0] s1_value_r;
  logic        s1_negative_r;
  logic [1:0]  s1_index_r;

  // Display state and configuration.
  digit_vec_t  store_r;
  logic        negative_stored_r;
  logic [1:0]  point_digit_r;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_segments_r;
  logic [3:0]  out_digit_enable_r;

  digit_vec_t  conv_digits;
  logic        s1_load;
  logic        s1_show;
  logic        out_load;
  logic        in_take;
  logic [7:0]  seg_nxt;
  logic [3:0]  enable_nxt;

  mssd_bcd u_bcd (
    .value  (s1_value_r),
    .digits (conv_digits)
  );

  // A load never needs the result register, so it always retires. A show
  // waits only while a previous result is still held by the consumer.
  assign s1_load  = s1_valid_r && (s1_command_r == CMD_LOAD);
  assign s1_show  = s1_valid_r && (s1_command_r == CMD_SHOW);
  assign out_load = s1_show && !(out_valid_r && out_stall);
  assign in_stall = s1_show && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Segment decode for the position named by the show word.
  always_comb begin
    if ((s1_index_r == 2'd0) && negative_stored_r) begin
      seg_nxt = SEG_MINUS;
    end else begin
      seg_nxt = seg_of_digit(store_r[s1_index_r]);
    end
    if (s1_index_r == point_digit_r) begin
      seg_nxt = seg_nxt | SEG_POINT;
    end
    enable_nxt = ~(4'b0001 << s1_index_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      store_r           <= '0;
      negative_stored_r <= 1'b0;
      point_digit_r     <= POINT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_load) begin
        store_r           <= conv_digits;
        negative_stored_r <= s1_negative_r;
      end
      if (cfg_wr_en) begin
        point_digit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_command_r  <= in_command;
      s1_value_r    <= in_value;
      s1_negative_r <= in_negative;
      s1_index_r    <= in_digit_index;
    end
    if (out_load) begin
      out_segments_r     <= seg_nxt;
      out_digit_enable_r <= enable_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_segments_r;
  assign out_digit_enable = out_digit_enable_r;

  // A new result only ever comes from a show word in the input register.
  a_result_from_show : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_show))
    else $error("result produced without a show word");

  // Every result selects exactly one digit.
  a_one_digit_enabled : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones(out_digit_enable_r) == NUM_DIGITS - 1))
    else $error("digit enable does not select exactly one digit");

  // A load leaves its flag in the display state.
  a_load_updates_flag : assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> (negative_stored_r == $past(s1_negative_r)))
    else $error("negative flag not stored by load");

endmodule

### rtl/mssd_bcd.sv
module mssd_bcd (
  input  logic [15:0]          value,
  output mssd_pkg::digit_vec_t digits
);
  import mssd_pkg::*;

  logic [15:0] mag;
  logic [31:0] p1;
  logic [28:0] p2;
  logic [32:0] p3;
  logic [29:0] p4;
  logic [12:0] q1;
  logic [8:0]  q2;
  logic [5:0]  q3;
  logic [1:0]  q4;

  // Two's complement magnitude; the most negative value maps to 0x8000.
  assign mag = value[15] ? (~value + 16'd1) : value;

  // The four quotients are independent, so each is one constant multiply.
  assign p1 = 32'(mag) * 32'(RECIP_10);
  assign p2 = 29'(mag) * 29'(RECIP_100);
  assign p3 = 33'(mag) * 33'(RECIP_1000);
  assign p4 = 30'(mag) * 30'(RECIP_10000);

  assign q1 = 13'(p1 >> 19);
  assign q2 = 9'(p2 >> 19);
  assign q3 = 6'(p3 >> 26);
  assign q4 = 2'(p4 >> 27);

  // Position 0 is the thousands digit, the last position the ones digit.
  assign digits[3] = 4'(mag - (16'(q1) * 16'd10));
  assign digits[2] = 4'(q1 - (13'(q2) * 13'd10));
  assign digits[1] = 4'(q2 - (9'(q3) * 9'd10));
  assign digits[0] = 4'(q3 - (6'(q4) * 6'd10));

endmodule
